// ===== rtl/pts_pkg.sv =====
package pts_pkg;

  localparam int unsigned ClkW    = 27;
  localparam int unsigned FreqW   = 20;
  localparam int unsigned DutyW   = 16;
  localparam int unsigned PscW    = 16;
  localparam int unsigned CmpW    = 17;
  localparam int unsigned DivW    = 34;
  localparam int unsigned DivCntW = 6;

  localparam logic [9:0]       DutyFull = 10'd1000;
  localparam logic [FreqW-1:0] FreqMax  = 20'd20000;
  localparam logic [ClkW-1:0]  FastClkReset = 27'd84000000;
  localparam logic [ClkW-1:0]  SlowClkReset = 27'd42000000;

  typedef enum logic [2:0] {
    CmdInit    = 3'd0,
    CmdSetDuty = 3'd1,
    CmdSetFreq = 3'd2,
    CmdStart   = 3'd3,
    CmdStop    = 3'd4
  } cmd_e;

  localparam logic RegFastClk = 1'b0;
  localparam logic RegSlowClk = 1'b1;

endpackage

// ===== rtl/pts_div.sv =====
module pts_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pts_pkg::DivW-1:0]   num_i,
  input  logic [pts_pkg::DivW-1:0]   den_i,
  output logic                       done_o,
  output logic [pts_pkg::DivW-1:0]   quot_o
);
  // restoring divider, one quotient bit per cycle
  logic [pts_pkg::DivW-1:0]    rem_q, rem_d, num_q, num_d, den_q, den_d;
  logic [pts_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                        busy_q, busy_d, done_q, done_d;
  logic [pts_pkg::DivW:0]      trial;

  always_comb begin
    rem_d = rem_q; num_d = num_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q, num_q[pts_pkg::DivW-1]} - {1'b0, den_q};
    if (start_i) begin
      rem_d = '0; num_d = num_i; den_d = den_i; busy_d = 1'b1;
      cnt_d = pts_pkg::DivCntW'(pts_pkg::DivW);
    end else if (busy_q) begin
      if (!trial[pts_pkg::DivW]) rem_d = trial[pts_pkg::DivW-1:0];
      else rem_d = {rem_q[pts_pkg::DivW-2:0], num_q[pts_pkg::DivW-1]};
      num_d = {num_q[pts_pkg::DivW-2:0], ~trial[pts_pkg::DivW]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == pts_pkg::DivCntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; num_q <= num_d; den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;
endmodule

// ===== rtl/pwm_timer_settings_engine.sv =====
// error, start or stop strobe from StEmit; set duty runs StCmpMul, StCmpDiv, then StEmit
// init: StPer, StP only if the period exceeds 1000 timer clocks, StRel, then as set duty
// set frequency: as init up to StRel, then per channel StScMul, StScDiv and one StScNext beat
// throughput: one command at a time, busy high until the last beat has been strobed
// a 34-bit restoring divider (one bit per cycle) and a 17-step shift-add multiplier do all the arithmetic
// reset: settings clear, clock registers load defaults; valid_o strobes, receiver cannot stall
module pwm_timer_settings_engine #(
  parameter int unsigned NUM_TIMERS   = 4,
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [26:0] cfg_data_i,
  input  logic [2:0]  command_i,
  input  logic [2:0]  timer_index_i,
  input  logic [2:0]  channel_index_i,
  input  logic [19:0] frequency_hz_i,
  input  logic [15:0] duty_permille_i,
  output logic        valid_o,
  output logic        status_o,
  output logic [1:0]  out_channel_o,
  output logic [15:0] prescaler_o,
  output logic [15:0] reload_o,
  output logic [16:0] compare_o,
  output logic        counter_enabled_o,
  output logic        last_o
);
  localparam int unsigned TW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned DW = pts_pkg::DivW;

  typedef enum logic [3:0] {
    StIdle, StPer, StP, StRel, StCmpMul, StCmpDiv, StScMul, StScDiv, StScNext,
    StEmit
  } state_e;

  logic [pts_pkg::ClkW-1:0] fast_clk_q, slow_clk_q;

  logic [15:0] psc_q [NUM_TIMERS];
  logic [15:0] rel_q [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] con_q;
  logic [16:0] cmp_q  [NUM_TIMERS][NUM_CHANNELS];
  logic [15:0] rcp_q  [NUM_TIMERS][NUM_CHANNELS];
  logic [9:0]  duty_q [NUM_TIMERS][NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] run_q [NUM_TIMERS];

  state_e      state_q;
  logic [2:0]  cmd_q;
  logic [TW-1:0] t_q;
  logic [CW-1:0] c_q;
  logic [9:0]  duty_l_q;
  logic [DW-1:0] per_q, p_q;
  logic [15:0] nrel_q, orel_q;
  logic [16:0] res_cmp_q;
  logic        err_q, last_q;

  // bit-serial multiplier: multiplicand shifts left, multiplier shifts right
  logic [DW-1:0] macc_q, mcand_q;
  logic [16:0]   mplr_q;
  logic [4:0]    mcnt_q;

  logic          div_go;
  logic [DW-1:0] div_num, div_den, div_quot;
  logic          div_done;

  // input decode
  logic freq_bad, idx_bad, duty_bad;
  assign freq_bad = (frequency_hz_i == '0) || (frequency_hz_i > pts_pkg::FreqMax);
  assign duty_bad = duty_permille_i > 16'(pts_pkg::DutyFull);
  always_comb begin
    idx_bad = (command_i > pts_pkg::CmdStop) || (32'(timer_index_i) >= NUM_TIMERS);
    if (command_i != pts_pkg::CmdSetFreq && 32'(channel_index_i) >= NUM_CHANNELS)
      idx_bad = 1'b1;
    if (command_i == pts_pkg::CmdInit && (freq_bad || duty_bad)) idx_bad = 1'b1;
    if (command_i == pts_pkg::CmdSetDuty && duty_bad) idx_bad = 1'b1;
    if (command_i == pts_pkg::CmdSetFreq && freq_bad) idx_bad = 1'b1;
  end

  logic accept;
  assign accept = start && !busy;
  assign busy = state_q != StIdle;

  logic [pts_pkg::ClkW-1:0] clk_sel;
  assign clk_sel = (timer_index_i == '0) ? fast_clk_q : slow_clk_q;

  // derived period split terms
  logic [15:0] rel_fix;
  always_comb begin
    rel_fix = 16'(div_quot - 1'b1);
    if (rel_fix == '0) rel_fix = 16'd1;
  end

  always_comb begin
    div_go = 1'b0; div_num = '0; div_den = '0;
    case (state_q)
      StIdle: begin
        div_go = accept && !idx_bad &&
          (command_i == pts_pkg::CmdInit || command_i == pts_pkg::CmdSetFreq);
        div_num = DW'(clk_sel); div_den = DW'(frequency_hz_i);
      end
      default: ;
    endcase
  end

  // second-stage divider starts come from registered requests
  logic          go2_q;
  logic [DW-1:0] num2_q, den2_q;
  logic          go_mux;
  assign go_mux = div_go || go2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_clk_q <= pts_pkg::FastClkReset;
      slow_clk_q <= pts_pkg::SlowClkReset;
      state_q <= StIdle;
      valid_o <= 1'b0;
      go2_q   <= 1'b0;
      con_q   <= '0;
      for (int t = 0; t < NUM_TIMERS; t++) begin
        psc_q[t] <= '0; rel_q[t] <= '0; run_q[t] <= '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          cmp_q[t][c] <= '0; rcp_q[t][c] <= '0; duty_q[t][c] <= '0;
        end
      end
    end else begin
      valid_o <= 1'b0;
      go2_q   <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == pts_pkg::RegFastClk) fast_clk_q <= cfg_data_i;
        else slow_clk_q <= cfg_data_i;
      end
      case (state_q)
        StIdle: if (accept) begin
          cmd_q    <= command_i;
          t_q      <= TW'(timer_index_i);
          c_q      <= (32'(channel_index_i) < NUM_CHANNELS) ? CW'(channel_index_i) : '0;
          duty_l_q <= duty_permille_i[9:0];
          err_q    <= idx_bad;
          last_q   <= 1'b1;
          if (idx_bad) state_q <= StEmit;
          else begin
            case (command_i)
              pts_pkg::CmdInit, pts_pkg::CmdSetFreq: state_q <= StPer;
              pts_pkg::CmdSetDuty: begin
                mcand_q <= DW'(rcp_q[TW'(timer_index_i)][CW'(channel_index_i)]) + 1'b1;
                mplr_q  <= 17'(duty_permille_i[9:0]);
                macc_q  <= '0; mcnt_q <= '0;
                state_q <= StCmpMul;
              end
              pts_pkg::CmdStart: begin
                run_q[TW'(timer_index_i)][CW'(channel_index_i)] <= 1'b1;
                con_q[TW'(timer_index_i)] <= 1'b1;
                res_cmp_q <= cmp_q[TW'(timer_index_i)][CW'(channel_index_i)];
                state_q <= StEmit;
              end
              default: begin
                run_q[TW'(timer_index_i)][CW'(channel_index_i)] <= 1'b0;
                if ((run_q[TW'(timer_index_i)] &
                     ~(NUM_CHANNELS'(1) << channel_index_i)) == '0)
                  con_q[TW'(timer_index_i)] <= 1'b0;
                res_cmp_q <= cmp_q[TW'(timer_index_i)][CW'(channel_index_i)];
                state_q <= StEmit;
              end
            endcase
          end
        end
        StPer: if (div_done) begin
          per_q <= div_quot;
          if (div_quot <= DW'(pts_pkg::DutyFull)) begin
            p_q <= '0;
            nrel_q <= (16'(div_quot - 1'b1) == '0) ? 16'd1 : 16'(div_quot - 1'b1);
            state_q <= StRel;
            go2_q <= 1'b0;
          end else begin
            go2_q <= 1'b1; num2_q <= div_quot; den2_q <= DW'(pts_pkg::DutyFull);
            state_q <= StP;
          end
        end
        StP: if (div_done) begin
          p_q <= (div_quot > DW'(65536)) ? DW'(65536) : div_quot;
          go2_q <= 1'b1; num2_q <= per_q;
          den2_q <= (div_quot > DW'(65536)) ? DW'(65536) : div_quot;
          state_q <= StRel;
        end
        StRel: if (p_q == '0 || div_done) begin
          logic [15:0] nr;
          nr = (p_q == '0) ? nrel_q : rel_fix;
          nrel_q  <= nr;
          orel_q  <= rel_q[t_q];
          psc_q[t_q] <= (p_q == '0) ? 16'd0 : 16'(p_q - 1'b1);
          rel_q[t_q] <= nr;
          p_q <= '0;
          if (cmd_q == pts_pkg::CmdInit) begin
            rcp_q[t_q][c_q]  <= nr;
            duty_q[t_q][c_q] <= duty_l_q;
            mcand_q <= DW'(nr) + 1'b1;
            mplr_q  <= 17'(duty_l_q);
            macc_q  <= '0; mcnt_q <= '0;
            state_q <= StCmpMul;
          end else begin
            // counter state is final for every beat of the rescale
            con_q[t_q] <= (run_q[t_q] != '0);
            c_q <= '0;
            state_q <= StScMul;
            mcnt_q <= '0; macc_q <= '0;
            mcand_q <= DW'(nr) + 1'b1;
            mplr_q  <= cmp_q[t_q][0];
          end
        end
        StCmpMul: begin
          if (mplr_q[0]) macc_q <= macc_q + mcand_q;
          mcand_q <= mcand_q << 1;
          mplr_q  <= mplr_q >> 1;
          mcnt_q  <= mcnt_q + 1'b1;
          if (mcnt_q == 5'd16) begin
            go2_q <= 1'b1; num2_q <= macc_q + (mplr_q[0] ? mcand_q : '0);
            den2_q <= DW'(pts_pkg::DutyFull);
            state_q <= StCmpDiv;
          end
        end
        StCmpDiv: if (div_done) begin
          cmp_q[t_q][c_q]  <= 17'(div_quot);
          duty_q[t_q][c_q] <= duty_l_q;
          res_cmp_q <= 17'(div_quot);
          state_q <= StEmit;
        end
        StScMul: begin
          if (mplr_q[0]) macc_q <= macc_q + mcand_q;
          mcand_q <= mcand_q << 1;
          mplr_q  <= mplr_q >> 1;
          mcnt_q  <= mcnt_q + 1'b1;
          if (mcnt_q == 5'd16) begin
            go2_q <= 1'b1; num2_q <= macc_q + (mplr_q[0] ? mcand_q : '0);
            den2_q <= DW'(orel_q) + 1'b1;
            state_q <= StScDiv;
          end
        end
        StScDiv: if (div_done) begin
          logic [16:0] v;
          v = (div_quot > DW'(nrel_q)) ? 17'(nrel_q) : 17'(div_quot);
          if (duty_q[t_q][c_q] != '0) v = v;
          else v = cmp_q[t_q][c_q];
          cmp_q[t_q][c_q] <= v;
          rcp_q[t_q][c_q] <= nrel_q;
          res_cmp_q <= v;
          last_q <= 32'(c_q) == NUM_CHANNELS - 1;
          state_q <= StScNext;
        end
        StScNext: begin
          // emit this channel, then move on
          valid_o <= 1'b1;
          status_o <= 1'b0; out_channel_o <= 2'(c_q);
          prescaler_o <= psc_q[t_q]; reload_o <= rel_q[t_q];
          compare_o <= res_cmp_q; counter_enabled_o <= con_q[t_q];
          last_o <= last_q;
          if (last_q) state_q <= StIdle;
          else begin
            c_q <= c_q + 1'b1;
            mcnt_q <= '0; macc_q <= '0;
            mcand_q <= DW'(nrel_q) + 1'b1;
            mplr_q  <= cmp_q[t_q][c_q + 1'b1];
            state_q <= StScMul;
          end
        end
        StEmit: begin
          valid_o <= 1'b1;
          status_o <= err_q;
          out_channel_o <= err_q ? 2'd0 : 2'(c_q);
          prescaler_o <= err_q ? '0 : psc_q[t_q];
          reload_o <= err_q ? '0 : rel_q[t_q];
          compare_o <= err_q ? '0 : res_cmp_q;
          counter_enabled_o <= err_q ? 1'b0 : con_q[t_q];
          last_o <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // chained divides take their start and operands from the registered go2_q, num2_q and den2_q
  logic [DW-1:0] dn_mux, dd_mux;
  assign dn_mux = go2_q ? num2_q : div_num;
  assign dd_mux = go2_q ? den2_q : div_den;

  pts_div u_div (
    .clk_i, .rst_ni, .start_i(go_mux), .num_i(dn_mux), .den_i(dd_mux),
    .done_o(div_done), .quot_o(div_quot)
  );

endmodule
